// ----- src/arp_pkg.sv -----
// Shared types, character constants and pattern tables for the AT response parser.
package arp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OK,
    ST_READY,
    ST_HEADER,
    ST_LENGTH,
    ST_PAYLOAD,
    ST_PROMPT
  } state_e;

  typedef enum logic [2:0] {
    EV_OK,
    EV_READY,
    EV_PROMPT,
    EV_DATA,
    EV_LENERR
  } event_e;

  typedef struct packed {
    event_e      ev;
    logic [7:0]  data;
    logic        last;
    logic [11:0] len;
  } result_t;

  localparam logic [7:0] ChO     = 8'h4F;
  localparam logic [7:0] ChK     = 8'h4B;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChE     = 8'h65;
  localparam logic [7:0] ChA     = 8'h61;
  localparam logic [7:0] ChD     = 8'h64;
  localparam logic [7:0] ChY     = 8'h79;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChBigI  = 8'h49;
  localparam logic [7:0] ChBigP  = 8'h50;
  localparam logic [7:0] ChBigD  = 8'h44;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // Expected byte at position idx of the reply selected by st.
  function automatic logic [7:0] pattern_char(state_e st, logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (st)
      ST_OK: begin
        case (idx)
          3'd0: c = ChO;
          3'd1: c = ChK;
          3'd2: c = ChCr;
          3'd3: c = ChLf;
          default: c = 8'h00;
        endcase
      end
      ST_READY: begin
        case (idx)
          3'd0: c = ChR;
          3'd1: c = ChE;
          3'd2: c = ChA;
          3'd3: c = ChD;
          3'd4: c = ChY;
          3'd5: c = ChCr;
          3'd6: c = ChLf;
          default: c = 8'h00;
        endcase
      end
      ST_PROMPT: begin
        case (idx)
          3'd0: c = ChGt;
          3'd1: c = ChSp;
          default: c = 8'h00;
        endcase
      end
      ST_HEADER: begin
        case (idx)
          3'd0: c = ChPlus;
          3'd1: c = ChBigI;
          3'd2: c = ChBigP;
          3'd3: c = ChBigD;
          3'd4: c = ChComma;
          3'd5: c = ChOne;
          3'd6: c = ChComma;
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] pattern_len(state_e st);
    logic [2:0] n;
    case (st)
      ST_OK:     n = 3'd4;
      ST_READY:  n = 3'd7;
      ST_PROMPT: n = 3'd2;
      ST_HEADER: n = 3'd7;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

// ----- src/arp_parser.sv -----
// Parser state registers and the per-byte next-state and result logic.
module arp_parser #(
  parameter int MAX_PAYLOAD = 2048
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [7:0]      byte_i,
  output logic            emit_o,
  output arp_pkg::result_t res_o
);
  import arp_pkg::*;

  localparam int LenW = $clog2(MAX_PAYLOAD + 1);
  localparam int CntW = (LenW > 3) ? LenW : 3;
  localparam int AccW = LenW + 4;
  localparam int ExtW = LenW + 12;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [LenW-1:0]   len_q, len_d;
  logic              started_q, started_d;
  logic              ended_q, ended_d;
  logic              ovf_q, ovf_d;

  logic [2:0]        idx;
  logic [3:0]        idx_inc;
  logic [CntW:0]     cnt_inc;
  logic [3:0]        digit;
  logic [AccW-1:0]   acc;
  logic [ExtW-1:0]   len_ext;
  logic              is_digit;

  assign idx      = cnt_q[2:0];
  assign idx_inc  = {1'b0, idx} + 4'd1;
  assign cnt_inc  = {1'b0, cnt_q} + {{CntW{1'b0}}, 1'b1};
  assign digit    = 4'(byte_i - ChZero);
  assign is_digit = (byte_i >= ChZero) && (byte_i <= ChNine);
  // times ten as two shifts and an add
  assign acc      = (AccW'(len_q) << 3) + (AccW'(len_q) << 1) + AccW'(digit);
  assign len_ext  = ExtW'(len_q);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    started_d = started_q;
    ended_d   = ended_q;
    ovf_d     = ovf_q;
    emit_o    = 1'b0;
    res_o     = '{ev: EV_OK, data: 8'h00, last: 1'b0, len: 12'h000};
    case (state_q)
      ST_IDLE: begin
        cnt_d = CntW'(1);
        if (byte_i == ChO) begin
          state_d = ST_OK;
        end else if (byte_i == ChR) begin
          state_d = ST_READY;
        end else if (byte_i == ChPlus) begin
          state_d = ST_HEADER;
        end else if (byte_i == ChGt) begin
          state_d = ST_PROMPT;
        end
      end
      ST_OK, ST_READY, ST_PROMPT, ST_HEADER: begin
        if (byte_i != pattern_char(state_q, idx)) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_inc[CntW-1:0];
          if (idx_inc == {1'b0, pattern_len(state_q)}) begin
            state_d = ST_IDLE;
            case (state_q)
              ST_OK: begin
                emit_o = 1'b1;
                res_o.ev = EV_OK;
              end
              ST_READY: begin
                emit_o = 1'b1;
                res_o.ev = EV_READY;
              end
              ST_PROMPT: begin
                emit_o = 1'b1;
                res_o.ev = EV_PROMPT;
              end
              default: begin
                // header done, start a fresh length field
                state_d   = ST_LENGTH;
                cnt_d     = '0;
                len_d     = '0;
                started_d = 1'b0;
                ended_d   = 1'b0;
                ovf_d     = 1'b0;
              end
            endcase
          end
        end
      end
      ST_LENGTH: begin
        if (byte_i == ChColon) begin
          if (!started_q || ovf_q) begin
            state_d  = ST_IDLE;
            emit_o   = 1'b1;
            res_o.ev = EV_LENERR;
          end else begin
            state_d = ST_PAYLOAD;
            cnt_d   = '0;
          end
        end else if (!ended_q && is_digit) begin
          started_d = 1'b1;
          if (!ovf_q) begin
            if (acc > AccW'(MAX_PAYLOAD)) begin
              ovf_d = 1'b1;
            end else begin
              len_d = acc[LenW-1:0];
            end
          end
        end else begin
          ended_d = 1'b1;
        end
      end
      ST_PAYLOAD: begin
        cnt_d      = cnt_inc[CntW-1:0];
        emit_o     = 1'b1;
        res_o.ev   = EV_DATA;
        res_o.data = byte_i;
        res_o.len  = len_ext[11:0];
        // a zero length still ends on the first byte
        res_o.last = (cnt_inc >= (CntW + 1)'(len_q));
        if (res_o.last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (!en_i) begin
      emit_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      len_q     <= '0;
      started_q <= 1'b0;
      ended_q   <= 1'b0;
      ovf_q     <= 1'b0;
    end else if (en_i) begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      len_q     <= len_d;
      started_q <= started_d;
      ended_q   <= ended_d;
      ovf_q     <= ovf_d;
    end
  end

endmodule

// ----- src/arp_out_reg.sv -----
// Result register that holds one result item until the consumer takes it.
module arp_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  arp_pkg::result_t res_i,
  output logic             free_o,
  output logic             valid_o,
  input  logic             ready_i,
  output arp_pkg::result_t res_o
);
  import arp_pkg::*;

  logic    vld_q, vld_d;
  result_t res_q;

  assign free_o  = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign res_o   = res_q;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ----- src/at_response_parser.sv -----
// Top level of the AT response parser: input register, parser, result register.
//
//  channel | direction | handshake               | payload
//  rx      | in        | rx_valid_i / rx_ready_o | rx_byte_i
//  res     | out       | res_valid_o / res_ready_i | event_res_o, payload_byte_o,
//          |           |                         | payload_last_o, payload_length_o
//
// One byte per cycle sustained while the output is not stalled. A byte is registered on
// transfer and parsed once the result register is free; its result (if any) is loaded at
// the end of that cycle, so res_valid_o follows the rx transfer through both registers.
// The parser advances only when the result register is empty or being read, so
// a stalled output holds one result plus one registered input byte.
// Reset clears the parser to idle and empties both registers.
module at_response_parser #(
  parameter int MAX_PAYLOAD = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [2:0]  event_res_o,
  output logic [7:0]  payload_byte_o,
  output logic        payload_last_o,
  output logic [11:0] payload_length_o
);
  import arp_pkg::*;

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       proc_go;
  logic       out_free;
  logic       emit;
  result_t    res_new;
  result_t    res_cur;

  assign proc_go    = in_vld_q && out_free;
  assign rx_ready_o = !in_vld_q || proc_go;

  always_comb begin
    in_vld_d = in_vld_q;
    if (rx_valid_i && rx_ready_o) begin
      in_vld_d = 1'b1;
    end else if (proc_go) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && rx_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  arp_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (proc_go),
    .byte_i (in_byte_q),
    .emit_o (emit),
    .res_o  (res_new)
  );

  arp_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (emit),
    .res_i   (res_new),
    .free_o  (out_free),
    .valid_o (res_valid_o),
    .ready_i (res_ready_i),
    .res_o   (res_cur)
  );

  assign event_res_o      = res_cur.ev;
  assign payload_byte_o   = res_cur.data;
  assign payload_last_o   = res_cur.last;
  assign payload_length_o = res_cur.len;

endmodule

// ----- src/arp_checker.sv -----
// Port-level checks for the AT response parser, bound to the top level.
module arp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rx_valid_i,
  input logic        rx_ready_o,
  input logic        res_valid_o,
  input logic        res_ready_i,
  input logic [2:0]  event_res_o,
  input logic [7:0]  payload_byte_o,
  input logic        payload_last_o,
  input logic [11:0] payload_length_o
);
  import arp_pkg::*;

  // a new result needs an earlier byte transfer on the input, checked with $past
  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_o) |-> $past(rx_valid_i && rx_ready_o, 2))
    else $error("result without a preceding input transfer");

  a_event_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (event_res_o == EV_OK || event_res_o == EV_READY ||
                     event_res_o == EV_PROMPT || event_res_o == EV_DATA ||
                     event_res_o == EV_LENERR))
    else $error("undefined event code");

  a_nondata_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && event_res_o != EV_DATA) |->
      (!payload_last_o && payload_byte_o == 8'h00 && payload_length_o == 12'h000))
    else $error("payload fields set on a non-data event");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ready_i) |=>
      (res_valid_o && $stable(event_res_o) && $stable(payload_byte_o) &&
       $stable(payload_last_o) && $stable(payload_length_o)))
    else $error("stalled result changed");

endmodule

bind at_response_parser arp_checker u_arp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rx_valid_i       (rx_valid_i),
  .rx_ready_o       (rx_ready_o),
  .res_valid_o      (res_valid_o),
  .res_ready_i      (res_ready_i),
  .event_res_o      (event_res_o),
  .payload_byte_o   (payload_byte_o),
  .payload_last_o   (payload_last_o),
  .payload_length_o (payload_length_o)
);
